// ===== hdl/dstq_pkg.sv =====
// ----------------------------------------------------------------------------
// dstq_pkg: shared types and constants of the deadline sorted timer queue
// Sizes, result kinds and the control word that drives the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dstq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int TIME_BITS     = 20;
   localparam int DEADLINE_BITS = TIME_BITS + 1;
   localparam int OCC_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_BITS       = 8;
   localparam int VALUE_BITS    = 32;
   localparam int DELAY_BITS    = 32;

   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_FULL     = 2'd1,
      KIND_EXPIRED  = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_SHIFT  = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic [DEADLINE_BITS-1:0]   deadline;
      logic [ID_BITS-1:0]         id;
      logic signed [VALUE_BITS-1:0] value;
   } entry_type;

   // broadcast to every cell in a cycle
   typedef struct packed {
      cell_op_type              op;
      logic [DEADLINE_BITS-1:0] key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/dstq_cell.sv =====
// ----------------------------------------------------------------------------
// dstq_cell: one slot of the sorted timer row
// Holds one entry, compares its deadline against the broadcast key, and
// either keeps, takes the new entry, takes the left neighbor or the right one.
// ----------------------------------------------------------------------------
`default_nettype none

module dstq_cell (
   input  wire logic                   clock,
   input  wire dstq_pkg::cell_ctrl_type ctrl,
   input  wire logic                   valid,
   input  wire logic                   left_le,
   input  wire dstq_pkg::entry_type    new_entry,
   input  wire dstq_pkg::entry_type    left_entry,
   input  wire dstq_pkg::entry_type    right_entry,
   output dstq_pkg::entry_type         entry,
   output logic                        le
);

   dstq_pkg::entry_type entry_ff, entry_in;

   // valid entry whose deadline is at or below the key
   assign le    = valid && (entry_ff.deadline <= ctrl.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         dstq_pkg::OP_HOLD: begin
            entry_in = entry_ff;
         end
         dstq_pkg::OP_INSERT: begin
            // entries after the insertion point move one slot right
            if (!le) begin
               if (left_le) begin
                  entry_in = new_entry;
               end else begin
                  entry_in = left_entry;
               end
            end
         end
         dstq_pkg::OP_SHIFT: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== hdl/deadline_sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue: timer queue kept sorted by deadline
// A row of cells holds the pending timers, earliest deadline at cell 0.
// Inserts place the timer at its sorted slot; checks pop due timers from the head.
// ----------------------------------------------------------------------------
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  request | req_valid/ready, func, current_time, delay,   | in
//          | timer_id, callback_value                      |
//  result  | rsp_valid/ready, kind, fired_id, fired_value, | out
//          | last                                          |
//
// Insert: the cells all compare in the accept cycle and shift right past the
//   insertion point at that edge; the answer sits in the output register the
//   next cycle. One request per cycle while the result side keeps up and no check is busy.
// Check: the accept captures the time, then one result per cycle while the result
//   side keeps up, each pop shifting the whole row left by one cell; a single none
//   result answers a check when nothing is due.
// The output register is the only stall point: while a result waits, the
//   row holds and req_ready stays low.
// Reset clears occupancy, the sequencer and rsp_valid; cell contents are
//   left as they are and only read below occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_sorted_timer_queue (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_ready,
   input  wire logic                                       req_func,
   input  wire logic [dstq_pkg::TIME_BITS-1:0]             req_current_time,
   input  wire logic [dstq_pkg::DELAY_BITS-1:0]            req_delay_ticks,
   input  wire logic [dstq_pkg::ID_BITS-1:0]               req_timer_id,
   input  wire logic signed [dstq_pkg::VALUE_BITS-1:0]     req_callback_value,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_ready,
   output logic [1:0]                                      rsp_kind,
   output logic [dstq_pkg::ID_BITS-1:0]                    rsp_fired_id,
   output logic signed [dstq_pkg::VALUE_BITS-1:0]          rsp_fired_value,
   output logic                                            rsp_last
);

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_CHECK = 1'b1
   } state_type;

   state_type state_ff, state_in;

   logic [dstq_pkg::OCC_BITS-1:0]   occ_ff, occ_in;
   logic [dstq_pkg::TIME_BITS-1:0]  now_ff, now_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   dstq_pkg::kind_type                     rsp_kind_ff, rsp_kind_in;
   logic [dstq_pkg::ID_BITS-1:0]           rsp_id_ff, rsp_id_in;
   logic signed [dstq_pkg::VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                                   rsp_last_ff, rsp_last_in;

   dstq_pkg::cell_ctrl_type             ctrl;
   dstq_pkg::entry_type                 new_entry;
   logic [dstq_pkg::DEADLINE_BITS-1:0]  ins_deadline;

   dstq_pkg::entry_type cell_entry [dstq_pkg::QUEUE_DEPTH];
   dstq_pkg::entry_type left_entry [dstq_pkg::QUEUE_DEPTH];
   dstq_pkg::entry_type right_entry[dstq_pkg::QUEUE_DEPTH];
   logic [dstq_pkg::QUEUE_DEPTH-1:0] cell_le;
   logic [dstq_pkg::QUEUE_DEPTH-1:0] left_le;
   logic [dstq_pkg::QUEUE_DEPTH-1:0] cell_valid;

   logic accept;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // deadline = now + (delay mod 2^TIME_BITS), one bit wider, no wrap
   assign ins_deadline = {1'b0, req_current_time}
                       + {1'b0, req_delay_ticks[dstq_pkg::TIME_BITS-1:0]};

   assign new_entry.deadline = ins_deadline;
   assign new_entry.id       = req_timer_id;
   assign new_entry.value    = req_callback_value;

   // neighbor wiring; the ends are tied off
   always_comb begin
      for (int i = 0; i < dstq_pkg::QUEUE_DEPTH; i++) begin
         if (i == 0) begin
            left_le[i]    = 1'b1;
            left_entry[i] = new_entry;
         end else begin
            left_le[i]    = cell_le[i-1];
            left_entry[i] = cell_entry[i-1];
         end
         if (i == dstq_pkg::QUEUE_DEPTH - 1) begin
            right_entry[i] = cell_entry[i];
         end else begin
            right_entry[i] = cell_entry[i+1];
         end
      end
   end

   for (genvar g = 0; g < dstq_pkg::QUEUE_DEPTH; g++) begin : g_cell
      assign cell_valid[g] = (occ_ff > dstq_pkg::OCC_BITS'(g));

      dstq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .valid       (cell_valid[g]),
         .left_le     (left_le[g]),
         .new_entry   (new_entry),
         .left_entry  (left_entry[g]),
         .right_entry (right_entry[g]),
         .entry       (cell_entry[g]),
         .le          (cell_le[g])
      );
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl.op      = dstq_pkg::OP_HOLD;
      // key: insert deadline while idle, captured time while popping
      ctrl.key     = (state_ff == ST_IDLE) ? ins_deadline : {1'b0, now_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_func) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = '0;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  if (occ_ff == dstq_pkg::OCC_BITS'(dstq_pkg::QUEUE_DEPTH)) begin
                     rsp_kind_in = dstq_pkg::KIND_FULL;
                  end else begin
                     rsp_kind_in = dstq_pkg::KIND_ACCEPTED;
                     ctrl.op     = dstq_pkg::OP_INSERT;
                     occ_in      = occ_ff + dstq_pkg::OCC_BITS'(1);
                  end
               end else begin
                  now_in   = req_current_time;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (cell_le[0]) begin
                  // head is due: emit it and pull the row left
                  rsp_kind_in  = dstq_pkg::KIND_EXPIRED;
                  rsp_id_in    = cell_entry[0].id;
                  rsp_value_in = cell_entry[0].value;
                  rsp_last_in  = !cell_le[1];
                  ctrl.op      = dstq_pkg::OP_SHIFT;
                  occ_in       = occ_ff - dstq_pkg::OCC_BITS'(1);
                  if (!cell_le[1]) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  // only reached on the first pass: nothing due
                  rsp_kind_in  = dstq_pkg::KIND_NONE;
                  rsp_id_in    = '0;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_fired_id    = rsp_id_ff;
   assign rsp_fired_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= dstq_pkg::OCC_BITS'(dstq_pkg::QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("request taken while popping");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_func
         && occ_ff != dstq_pkg::OCC_BITS'(dstq_pkg::QUEUE_DEPTH))
      |=> (occ_ff == $past(occ_ff) + dstq_pkg::OCC_BITS'(1)))
      else $error("insert did not grow occupancy");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && out_free && cell_le[0])
      |=> (occ_ff == $past(occ_ff) - dstq_pkg::OCC_BITS'(1)) && rsp_valid_ff
          && (rsp_kind_ff == dstq_pkg::KIND_EXPIRED))
      else $error("pop did not shrink occupancy");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the deadline sorted timer queue
// Drives insert and expiry-check requests, runs a local copy of the sorted
// timer list and compares every answer field by field.
// ----------------------------------------------------------------------------

module tb_top;

   // request function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_CHECK  = 1'b1;

   // result kinds, short names for the stimulus table
   localparam dstq_pkg::kind_type K_ACCEPTED = dstq_pkg::KIND_ACCEPTED;
   localparam dstq_pkg::kind_type K_FULL     = dstq_pkg::KIND_FULL;
   localparam dstq_pkg::kind_type K_EXPIRED  = dstq_pkg::KIND_EXPIRED;
   localparam dstq_pkg::kind_type K_NONE     = dstq_pkg::KIND_NONE;

   localparam int TIME_SPAN     = 1 << dstq_pkg::TIME_BITS;
   localparam int RANDOM_ITEMS  = 136;
   localparam int DIRECTED_ROWS = 24;
   // the limit leaves room for every request's work plus receiver stalls;
   // this is many times what the whole run needs
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int PRINT_CAP     = 40;

   // one request, plus an answer typed in for the obvious directed rows
   typedef struct packed {
      logic                                   func;
      logic [dstq_pkg::TIME_BITS-1:0]         current_time;
      logic [dstq_pkg::DELAY_BITS-1:0]        delay_ticks;
      logic [dstq_pkg::ID_BITS-1:0]           timer_id;
      logic signed [dstq_pkg::VALUE_BITS-1:0] callback_value;
      logic                                   has_answer;
      dstq_pkg::kind_type                     answer_kind;
   } timer_row_type;

   typedef struct packed {
      dstq_pkg::kind_type                     kind;
      logic [dstq_pkg::ID_BITS-1:0]           id;
      logic signed [dstq_pkg::VALUE_BITS-1:0] value;
      logic                                   last;
   } timer_answer_type;

   // ---------------------------------------------------------------------
   // clock, reset and block ports
   // ---------------------------------------------------------------------
   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_func = 1'b0;
   logic [dstq_pkg::TIME_BITS-1:0]         req_current_time = '0;
   logic [dstq_pkg::DELAY_BITS-1:0]        req_delay_ticks = '0;
   logic [dstq_pkg::ID_BITS-1:0]           req_timer_id = '0;
   logic signed [dstq_pkg::VALUE_BITS-1:0] req_callback_value = '0;
   logic                                   rsp_ready = 1'b0;
   wire                                    req_ready;
   wire                                    rsp_valid;
   wire [1:0]                              rsp_kind;
   wire [dstq_pkg::ID_BITS-1:0]            rsp_fired_id;
   wire signed [dstq_pkg::VALUE_BITS-1:0]  rsp_fired_value;
   wire                                    rsp_last;

   deadline_sorted_timer_queue dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_current_time   (req_current_time),
      .req_delay_ticks    (req_delay_ticks),
      .req_timer_id       (req_timer_id),
      .req_callback_value (req_callback_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_fired_id       (rsp_fired_id),
      .rsp_fired_value    (rsp_fired_value),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // local timer list: sorted by deadline, ties in insertion order
   // ---------------------------------------------------------------------
   logic [dstq_pkg::DEADLINE_BITS-1:0]     list_deadline [dstq_pkg::QUEUE_DEPTH];
   logic [dstq_pkg::ID_BITS-1:0]           list_id       [dstq_pkg::QUEUE_DEPTH];
   logic signed [dstq_pkg::VALUE_BITS-1:0] list_value    [dstq_pkg::QUEUE_DEPTH];
   int                                     list_count = 0;

   // answers still owed by the block, oldest first
   timer_answer_type              timer_answers [$];

   int                            fail_count  = 0;
   int                            cycle_count = 0;
   int                            burst_left  = 0;

   // Apply one accepted request to the list and collect the answers it owes.
   function automatic void apply_to_timer_list(input timer_row_type row,
                                               output timer_answer_type owed [$]);
      logic [dstq_pkg::DEADLINE_BITS-1:0] due;
      int                                 pos;
      int                                 popped;
      owed = {};
      if (row.func == FUNC_INSERT) begin
         if (list_count >= dstq_pkg::QUEUE_DEPTH) begin
            // full: timer dropped, list untouched
            owed.push_back('{K_FULL, '0, '0, 1'b1});
         end else begin
            // deadline kept one bit wider than the counter, no wrap
            due = dstq_pkg::DEADLINE_BITS'(row.current_time)
                + dstq_pkg::DEADLINE_BITS'(row.delay_ticks[dstq_pkg::TIME_BITS-1:0]);
            pos = 0;
            while (pos < list_count && list_deadline[pos] <= due) pos++;
            for (int i = list_count; i > pos; i--) begin
               list_deadline[i] = list_deadline[i-1];
               list_id[i]       = list_id[i-1];
               list_value[i]    = list_value[i-1];
            end
            list_deadline[pos] = due;
            list_id[pos]       = row.timer_id;
            list_value[pos]    = row.callback_value;
            list_count++;
            owed.push_back('{K_ACCEPTED, '0, '0, 1'b1});
         end
      end else begin
         popped = 0;
         while (popped < list_count
                && list_deadline[popped]
                   <= dstq_pkg::DEADLINE_BITS'(row.current_time))
            popped++;
         if (popped == 0) begin
            owed.push_back('{K_NONE, '0, '0, 1'b1});
         end else begin
            for (int i = 0; i < popped; i++)
               owed.push_back('{K_EXPIRED, list_id[i], list_value[i],
                                i + 1 == popped});
            for (int i = popped; i < list_count; i++) begin
               list_deadline[i-popped] = list_deadline[i];
               list_id[i-popped]       = list_id[i];
               list_value[i-popped]    = list_value[i];
            end
            list_count -= popped;
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_CAP)
         $display("[cycle %0d] mismatch: %s", cycle_count, what);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // request side: called at a rising edge; holds the request until it is
   // taken, records what it owes, then keeps going or idles per the burst
   // ---------------------------------------------------------------------
   task automatic issue_request(input timer_row_type row);
      timer_answer_type owed [$];
      req_valid          <= 1'b1;
      req_func           <= row.func;
      req_current_time   <= row.current_time;
      req_delay_ticks    <= row.delay_ticks;
      req_timer_id       <= row.timer_id;
      req_callback_value <= row.callback_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // taken at this edge
      apply_to_timer_list(row, owed);
      if (row.has_answer)
         timer_answers.push_back('{row.answer_kind, '0, '0, 1'b1});
      else
         foreach (owed[i]) timer_answers.push_back(owed[i]);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // ---------------------------------------------------------------------
   // result side: checks every taken answer and drives its own stall pattern
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;

   always @(posedge clock) begin
      timer_answer_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (timer_answers.size() == 0) begin
            report_mismatch($sformatf("answer with nothing owed: kind %0d id %0d",
                                      rsp_kind, rsp_fired_id));
         end else begin
            want = timer_answers.pop_front();
            if (rsp_kind != want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_fired_id != want.id)
               report_mismatch($sformatf("fired_id %0d, want %0d",
                                         rsp_fired_id, want.id));
            if (rsp_fired_value != want.value)
               report_mismatch($sformatf("fired_value %0d, want %0d",
                                         rsp_fired_value, want.value));
            if (rsp_last != want.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
         end
      end
      // stall pattern: free flow, light, heavy, or periodic runs of stalls
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 120);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= (cycle_count % 16) >= 5;
      endcase
   end

   // hard stop if the block hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   timer_row_type directed_rows [DIRECTED_ROWS];

   initial begin
      timer_row_type row;
      int            tick_now;
      int            headroom;
      int            stuck;

      // Directed part. Deadlines noted on each insert. The sixteen inserts
      // fill the list out of order with several ties, so the full check
      // pops all sixteen and shows both the sort and the tie order.
      directed_rows = '{
         // empty list right after reset
         '{FUNC_CHECK,  20'h00000, 32'h00000000, 8'h00, 32'sh00000000, 1'b1, K_NONE},
         '{FUNC_INSERT, 20'h00100, 32'h00000050, 8'h01, 32'sh7FFFFFFF, 1'b1, K_ACCEPTED}, // 150
         '{FUNC_INSERT, 20'h00100, 32'h00000010, 8'hFF, 32'sh80000000, 1'b1, K_ACCEPTED}, // 110
         '{FUNC_INSERT, 20'h00100, 32'h00000050, 8'h02, 32'shFFFFFFFF, 1'b1, K_ACCEPTED}, // 150 tie
         '{FUNC_INSERT, 20'h00000, 32'h000FFFFF, 8'h03, 32'sh00000000, 1'b1, K_ACCEPTED}, // FFFFF
         // upper delay bits are dropped
         '{FUNC_INSERT, 20'h00120, 32'hFFF00030, 8'h04, 32'sh12345678, 1'b1, K_ACCEPTED}, // 150 tie
         '{FUNC_INSERT, 20'h00200, 32'h00000000, 8'h05, 32'sh55555555, 1'b1, K_ACCEPTED}, // 200
         '{FUNC_INSERT, 20'h00000, 32'h00000110, 8'h06, 32'shAAAAAAAA, 1'b1, K_ACCEPTED}, // 110 tie
         '{FUNC_INSERT, 20'h7FFFF, 32'h00080000, 8'h07, 32'sh00000001, 1'b1, K_ACCEPTED}, // FFFFF tie
         '{FUNC_INSERT, 20'h00050, 32'h00000000, 8'h08, 32'shFFFFFFFE, 1'b1, K_ACCEPTED}, // 50
         '{FUNC_INSERT, 20'h00300, 32'h00000000, 8'h09, 32'sh0F0F0F0F, 1'b1, K_ACCEPTED}, // 300
         '{FUNC_INSERT, 20'h00100, 32'h00000040, 8'h0A, 32'shF0F0F0F0, 1'b1, K_ACCEPTED}, // 140
         '{FUNC_INSERT, 20'h00020, 32'h00000030, 8'h0B, 32'sh00000100, 1'b1, K_ACCEPTED}, // 50 tie
         '{FUNC_INSERT, 20'h40000, 32'h00040000, 8'h0C, 32'sh80000001, 1'b1, K_ACCEPTED}, // 80000
         '{FUNC_INSERT, 20'h3FFFF, 32'h00000001, 8'h0D, 32'sh00010000, 1'b1, K_ACCEPTED}, // 40000
         '{FUNC_INSERT, 20'h00151, 32'h00000000, 8'h0E, 32'sh3C3C3C3C, 1'b1, K_ACCEPTED}, // 151
         '{FUNC_INSERT, 20'h0FFFE, 32'h00000000, 8'h0F, 32'shC3C3C3C3, 1'b1, K_ACCEPTED}, // 0FFFE
         // seventeenth timer is dropped
         '{FUNC_INSERT, 20'h00000, 32'h00000000, 8'h10, 32'sh00000001, 1'b1, K_FULL},
         // top of the counter range pops the whole list
         '{FUNC_CHECK,  20'hFFFFF, 32'hFFFFFFFF, 8'hFF, 32'shFFFFFFFF, 1'b0, K_ACCEPTED},
         // deadlines past the counter range: they never expire
         '{FUNC_INSERT, 20'hFFFFF, 32'hFFFFFFFF, 8'h20, 32'sh11111111, 1'b1, K_ACCEPTED}, // 1FFFFE
         '{FUNC_INSERT, 20'h80000, 32'h00080000, 8'h21, 32'sh22222222, 1'b1, K_ACCEPTED}, // 100000
         '{FUNC_CHECK,  20'hFFFFF, 32'h00000000, 8'h00, 32'sh00000000, 1'b1, K_NONE},
         // deadline equal to the check time expires, the stuck ones stay
         '{FUNC_INSERT, 20'h7FFFF, 32'h00080000, 8'h22, 32'sh33333333, 1'b1, K_ACCEPTED}, // FFFFF
         '{FUNC_CHECK,  20'hFFFFF, 32'h00000000, 8'h00, 32'sh00000000, 1'b0, K_ACCEPTED}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(0, 10);

      foreach (directed_rows[i]) issue_request(directed_rows[i]);

      // Random part: a counter that moves forward, inserts with short delays
      // so entries come due within a few requests, and checks at the counter.
      // Some checks use any time at all; a few inserts land past the counter
      // range, capped so the stuck entries never crowd out the list.
      tick_now = $urandom_range(0, 'h20000);
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         tick_now += $urandom_range(0, 2500);
         if (tick_now > 'hF8000) tick_now = $urandom_range(0, 'h1000);
         row                = '0;
         row.timer_id       = dstq_pkg::ID_BITS'($urandom());
         row.callback_value = $urandom();
         row.delay_ticks    = $urandom();
         if ($urandom_range(0, 99) < 60) begin
            row.func         = FUNC_INSERT;
            row.current_time = dstq_pkg::TIME_BITS'(tick_now);
            stuck = 0;
            for (int i = 0; i < list_count; i++)
               if (list_deadline[i][dstq_pkg::TIME_BITS]) stuck++;
            headroom = TIME_SPAN - 1 - tick_now;
            if (headroom > 'h3000) headroom = 'h3000;
            if (stuck < 3 && tick_now > 0 && $urandom_range(0, 39) == 0)
               row.delay_ticks[dstq_pkg::TIME_BITS-1:0] = dstq_pkg::TIME_BITS'(
                  $urandom_range(TIME_SPAN - tick_now, TIME_SPAN - 1));
            else
               row.delay_ticks[dstq_pkg::TIME_BITS-1:0] =
                  dstq_pkg::TIME_BITS'($urandom_range(0, headroom));
         end else begin
            row.func         = FUNC_CHECK;
            row.current_time = ($urandom_range(0, 99) < 85)
                                  ? dstq_pkg::TIME_BITS'(tick_now)
                                  : dstq_pkg::TIME_BITS'($urandom());
         end
         issue_request(row);
      end
      req_valid <= 1'b0;

      // let every owed answer arrive, then a little longer for strays
      while (timer_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
